[rtl/ppmp_pkg.sv]
package ppmp_pkg;

    // Widths of the internal value path.
    localparam int TOKEN_W = 17;
    localparam int ACC_W   = 21;

    // Largest value the token accumulator may hold.
    localparam int TOKEN_CAP = 131071;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // Characters the front recognizes.
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Result event codes.
    localparam logic [1:0] EV_PIXEL  = 2'd0;
    localparam logic [1:0] EV_HEADER = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_NO_P    = 3'd1;
    localparam logic [2:0] ERR_FORMAT  = 3'd2;
    localparam logic [2:0] ERR_BINARY  = 3'd3;
    localparam logic [2:0] ERR_PIXELS  = 3'd4;

    // Header fields in the order they arrive.
    localparam logic [1:0] HF_WIDTH  = 2'd0;
    localparam logic [1:0] HF_HEIGHT = 2'd1;
    localparam logic [1:0] HF_MAXVAL = 2'd2;
    localparam logic [1:0] HF_DONE   = 2'd3;

    // Color channel slots.
    localparam logic [1:0] SLOT_RED   = 2'd0;
    localparam logic [1:0] SLOT_GREEN = 2'd1;
    localparam logic [1:0] SLOT_BLUE  = 2'd2;

    // One request on the input channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       new_file;
    } char_item_t;

    // One request on the result channel.
    typedef struct packed {
        logic [1:0]  event_res;
        logic [31:0] pixel_word;
        logic [23:0] pixel_index;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] max_value;
        logic [2:0]  error_code;
    } result_item_t;

    // Work handed from front to back: a decoded value or an error.
    typedef struct packed {
        logic               restart;
        logic               is_error;
        logic [2:0]         error_code;
        logic [TOKEN_W-1:0] value;
    } queue_entry_t;

    // Saturation limit of a decimal token of the given digit count.
    function automatic int token_limit(input int digits);
        int lim;
        lim = 1;
        for (int i = 0; i < 9; i++)
        begin
            if (i < digits && lim <= TOKEN_CAP + 1)
            begin
                lim = lim * 10;
            end
        end
        lim = lim - 1;
        return (lim < TOKEN_CAP) ? lim : TOKEN_CAP;
    endfunction

endpackage

[rtl/ascii_ppm_pixel_parser.sv]
// ASCII PPM (P3) parser: takes one character request per cycle and sends header,
// pixel and error results. A byte is taken in every cycle unless the four-entry
// work queue between the decoder and the pixel assembler is full, which happens
// only after the result side has stalled; the throughput is one byte per clock
// while the queue has room. With an empty queue and a free result register, the
// byte completing a result passes the queue write and then the result register
// before the result is valid. Setting new_file on a byte restarts the parser
// with that byte; until then, a parser that has sent an error ignores all bytes.
// Pixel words carry alpha 0xFF in the top byte, then blue, green, red.
module ascii_ppm_pixel_parser
    import ppmp_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int TOKEN_DIGITS  = 9
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_item_t   char_data,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    logic         push_valid;
    queue_entry_t push_entry;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    queue_entry_t q_entry;

    // Character decoder.
    ppmp_front #(
        .TOKEN_DIGITS (TOKEN_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // Work queue.
    ppmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    // Header and pixel assembly.
    ppmp_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

[rtl/ppmp_front.sv]
module ppmp_front
    import ppmp_pkg::*;
#(
    parameter int TOKEN_DIGITS = 9
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    output logic         char_stall,
    input  char_item_t   char_data,
    input  logic         q_full,
    output logic         push_valid,
    output queue_entry_t push_entry
);

    localparam logic [TOKEN_W-1:0] TokenLimit = TOKEN_W'(token_limit(TOKEN_DIGITS));

    typedef enum logic [3:0] {
        F_MAGIC  = 4'b0001,
        F_FORMAT = 4'b0010,
        F_BODY   = 4'b0100,
        F_HALT   = 4'b1000
    } front_state_t;

    front_state_t       phase_reg, phase_next, phase_cur;
    logic               comment_reg, comment_next, comment_cur;
    logic [TOKEN_W-1:0] token_reg, token_next, token_cur;
    logic               present_reg, present_next, present_cur;
    logic               binary_reg, binary_next, binary_cur;
    logic [1:0]         count_reg, count_next, count_cur;
    logic               restart_reg, restart_next, restart_cur;
    logic               accept;
    logic               produce;
    logic [7:0]         ch;
    logic [ACC_W-1:0]   acc;
    queue_entry_t       entry;

    assign accept     = char_valid & ~q_full;
    assign char_stall = q_full;
    assign ch         = char_data.data_byte;
    assign push_valid = accept & produce;
    assign push_entry = entry;

    // A new file restarts the front before its first byte is decoded.
    always_comb
    begin
        if (char_data.new_file)
        begin
            phase_cur   = F_MAGIC;
            comment_cur = 1'b0;
            token_cur   = '0;
            present_cur = 1'b0;
            binary_cur  = 1'b0;
            count_cur   = HF_WIDTH;
            restart_cur = 1'b1;
        end
        else
        begin
            phase_cur   = phase_reg;
            comment_cur = comment_reg;
            token_cur   = token_reg;
            present_cur = present_reg;
            binary_cur  = binary_reg;
            count_cur   = count_reg;
            restart_cur = restart_reg;
        end
    end

    // Classify the byte and decide what the back has to do with it.
    always_comb
    begin
        phase_next   = phase_cur;
        comment_next = comment_cur;
        token_next   = token_cur;
        present_next = present_cur;
        binary_next  = binary_cur;
        count_next   = count_cur;
        produce      = 1'b0;
        entry        = '0;
        acc          = ACC_W'(token_cur) * ACC_W'(10) + ACC_W'(ch[3:0]);

        case (phase_cur)
            F_MAGIC:
            begin
                if (ch != CH_P)
                begin
                    produce          = 1'b1;
                    entry.is_error   = 1'b1;
                    entry.error_code = ERR_NO_P;
                    phase_next       = F_HALT;
                end
                else
                begin
                    phase_next = F_FORMAT;
                end
            end
            F_FORMAT:
            begin
                if (ch == CH_3)
                begin
                    binary_next = 1'b0;
                    phase_next  = F_BODY;
                end
                else if (ch == CH_6)
                begin
                    binary_next = 1'b1;
                    phase_next  = F_BODY;
                end
                else
                begin
                    produce          = 1'b1;
                    entry.is_error   = 1'b1;
                    entry.error_code = ERR_FORMAT;
                    phase_next       = F_HALT;
                end
            end
            F_BODY:
            begin
                if (count_cur == HF_DONE && binary_cur)
                begin
                    // Binary pixel data is not decoded.
                    produce          = 1'b1;
                    entry.is_error   = 1'b1;
                    entry.error_code = ERR_BINARY;
                    phase_next       = F_HALT;
                end
                else if (comment_cur)
                begin
                    if (ch == CH_NL)
                    begin
                        comment_next = 1'b0;
                    end
                end
                else if (ch == CH_HASH)
                begin
                    comment_next = 1'b1;
                end
                else if (ch == CH_SPACE || ch == CH_NL)
                begin
                    if (present_cur)
                    begin
                        produce      = 1'b1;
                        entry.value  = token_cur;
                        token_next   = '0;
                        present_next = 1'b0;
                        if (count_cur != HF_DONE)
                        begin
                            count_next = count_cur + 2'd1;
                        end
                    end
                end
                else if (ch inside {[8'h30:8'h39]})
                begin
                    token_next   = (acc < ACC_W'(TokenLimit)) ? acc[TOKEN_W-1:0] : TokenLimit;
                    present_next = 1'b1;
                end
            end
            F_HALT:
            begin
                produce = 1'b0;
            end
            default:
            begin
                phase_next = F_HALT;
            end
        endcase

        entry.restart = restart_cur;
        restart_next  = produce ? 1'b0 : restart_cur;
    end

    // State update on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= F_MAGIC;
            comment_reg <= 1'b0;
            token_reg   <= '0;
            present_reg <= 1'b0;
            binary_reg  <= 1'b0;
            count_reg   <= HF_WIDTH;
            restart_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            token_reg   <= token_next;
            present_reg <= present_next;
            binary_reg  <= binary_next;
            count_reg   <= count_next;
            restart_reg <= restart_next;
        end
    end

    // A halted parser sends nothing until a new file starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == F_HALT && accept && !char_data.new_file) |-> !push_valid)
        else $error("front pushed work while halted");

    // An empty token never carries leftover digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !present_reg |-> (token_reg == '0))
        else $error("token value held without digits");

endmodule

[rtl/ppmp_queue.sv]
module ppmp_queue
    import ppmp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  queue_entry_t push_entry,
    output logic         full,
    output logic         pop_valid,
    input  logic         pop,
    output queue_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    queue_entry_t     slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push   = push_valid & ~full;
    assign do_pop    = pop & pop_valid;

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers wrap naturally because the depth is a power of two.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !full)
        else $error("push into a full queue");

endmodule

[rtl/ppmp_back.sv]
module ppmp_back
    import ppmp_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  queue_entry_t q_entry,
    output logic         pop,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_data
);

    localparam logic [12:0] DimLimit = 13'(MAX_DIMENSION);

    typedef enum logic [3:0] {
        B_HEADER = 4'b0001,
        B_PIXELS = 4'b0010,
        B_DONE   = 4'b0100,
        B_HALT   = 4'b1000
    } back_state_t;

    back_state_t  state_reg, state_next, state_cur;
    logic [1:0]   field_reg, field_next, field_cur;
    logic [12:0]  width_reg, width_next, width_cur;
    logic [12:0]  height_reg, height_next, height_cur;
    logic [15:0]  maxval_reg, maxval_next, maxval_cur;
    logic [24:0]  total_reg, total_next, total_cur;
    logic [23:0]  last_idx_reg, last_idx_next, last_idx_cur;
    logic [1:0]   slot_reg, slot_next, slot_cur;
    logic [7:0]   red_reg, red_next, red_cur;
    logic [7:0]   green_reg, green_next, green_cur;
    logic [23:0]  count_reg, count_next, count_cur;
    logic         out_valid_reg;
    result_item_t out_reg;
    result_item_t out_next;
    logic         emit;
    logic [12:0]  dim_val;
    logic [16:0]  chan_max;
    logic [7:0]   chan_val;
    logic [25:0]  product;
    logic [24:0]  total_m1;

    assign pop          = q_valid & (~out_valid_reg | ~result_stall);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // The first request after a new file starts from a cleared back.
    always_comb
    begin
        if (q_entry.restart)
        begin
            state_cur    = B_HEADER;
            field_cur    = HF_WIDTH;
            width_cur    = '0;
            height_cur   = '0;
            maxval_cur   = '0;
            total_cur    = '0;
            last_idx_cur = '0;
            slot_cur     = SLOT_RED;
            red_cur      = '0;
            green_cur    = '0;
            count_cur    = '0;
        end
        else
        begin
            state_cur    = state_reg;
            field_cur    = field_reg;
            width_cur    = width_reg;
            height_cur   = height_reg;
            maxval_cur   = maxval_reg;
            total_cur    = total_reg;
            last_idx_cur = last_idx_reg;
            slot_cur     = slot_reg;
            red_cur      = red_reg;
            green_cur    = green_reg;
            count_cur    = count_reg;
        end
    end

    // Value clamps and the image size product.
    always_comb
    begin
        dim_val  = (q_entry.value > 17'(DimLimit)) ? DimLimit : q_entry.value[12:0];
        chan_max = (q_entry.value > {1'b0, maxval_cur}) ? {1'b0, maxval_cur} : q_entry.value;
        chan_val = (chan_max > 17'd255) ? 8'd255 : chan_max[7:0];
        product  = 26'(width_cur) * 26'(dim_val);
        total_m1 = total_cur - 25'd1;
    end

    // Carry out one value or error.
    always_comb
    begin
        state_next    = state_cur;
        field_next    = field_cur;
        width_next    = width_cur;
        height_next   = height_cur;
        maxval_next   = maxval_cur;
        total_next    = total_cur;
        last_idx_next = last_idx_cur;
        slot_next     = slot_cur;
        red_next      = red_cur;
        green_next    = green_cur;
        count_next    = count_cur;
        emit          = 1'b0;
        out_next      = '0;

        if (q_entry.is_error)
        begin
            emit                = 1'b1;
            out_next.event_res  = EV_ERROR;
            out_next.error_code = q_entry.error_code;
            state_next          = B_HALT;
        end
        else
        begin
            case (state_cur)
                B_HEADER:
                begin
                    case (field_cur)
                        HF_WIDTH:
                        begin
                            width_next = dim_val;
                            field_next = HF_HEIGHT;
                        end
                        HF_HEIGHT:
                        begin
                            height_next = dim_val;
                            total_next  = product[24:0];
                            field_next  = HF_MAXVAL;
                        end
                        default:
                        begin
                            maxval_next   = (q_entry.value > 17'hFFFF) ? 16'hFFFF
                                                                        : q_entry.value[15:0];
                            field_next    = HF_DONE;
                            last_idx_next = total_m1[23:0];
                            state_next    = (total_cur == '0) ? B_DONE : B_PIXELS;
                            emit          = 1'b1;
                            out_next.event_res = EV_HEADER;
                        end
                    endcase
                end
                B_PIXELS, B_DONE:
                begin
                    case (slot_cur)
                        SLOT_RED:
                        begin
                            red_next  = chan_val;
                            slot_next = SLOT_GREEN;
                        end
                        SLOT_GREEN:
                        begin
                            green_next = chan_val;
                            slot_next  = SLOT_BLUE;
                        end
                        default:
                        begin
                            slot_next = SLOT_RED;
                            emit      = 1'b1;
                            if (state_cur == B_DONE)
                            begin
                                out_next.event_res  = EV_ERROR;
                                out_next.error_code = ERR_PIXELS;
                                state_next          = B_HALT;
                            end
                            else
                            begin
                                out_next.event_res   = EV_PIXEL;
                                out_next.pixel_word  = {8'hFF, chan_val, green_cur, red_cur};
                                out_next.pixel_index = count_cur;
                                out_next.last_pixel  = (count_cur == last_idx_cur);
                                if (count_cur == last_idx_cur)
                                begin
                                    state_next = B_DONE;
                                end
                                else
                                begin
                                    count_next = count_cur + 24'd1;
                                end
                            end
                        end
                    endcase
                end
                B_HALT:
                begin
                    emit = 1'b0;
                end
                default:
                begin
                    state_next = B_HALT;
                end
            endcase
        end

        out_next.image_width  = width_next;
        out_next.image_height = height_next;
        out_next.max_value    = maxval_next;
    end

    // Parser state advances on each popped request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_HEADER;
            field_reg    <= HF_WIDTH;
            width_reg    <= '0;
            height_reg   <= '0;
            maxval_reg   <= '0;
            total_reg    <= '0;
            last_idx_reg <= '0;
            slot_reg     <= SLOT_RED;
            red_reg      <= '0;
            green_reg    <= '0;
            count_reg    <= '0;
        end
        else if (pop)
        begin
            state_reg    <= state_next;
            field_reg    <= field_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            maxval_reg   <= maxval_next;
            total_reg    <= total_next;
            last_idx_reg <= last_idx_next;
            slot_reg     <= slot_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            count_reg    <= count_next;
        end
    end

    // Output register: loads on a result, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_reg <= out_next;
        end
    end

    // A pixel is never emitted past the last raster position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && emit && out_next.event_res == EV_PIXEL)
            |-> (out_next.pixel_index <= last_idx_cur))
        else $error("pixel index beyond image size");

    // A halted back stays silent until a restart or an error request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && state_reg == B_HALT && !q_entry.restart && !q_entry.is_error) |-> !emit)
        else $error("result emitted while halted");

endmodule

[test/tb_ascii_ppm_pixel_parser.sv]
module tb_ascii_ppm_pixel_parser
    import ppmp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIM        = 4096;
    localparam int unsigned MAXVAL_CAP     = 65535;
    localparam int          RANDOM_BYTES   = 1550;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          WATCHDOG_LIMIT = 4000;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] ALPHA   = 8'hFF;

    // Where the parser stands within the current file.
    typedef enum logic [5:0] {
        PH_EXPECT_P      = 6'b000001,
        PH_EXPECT_FORMAT = 6'b000010,
        PH_HEADER        = 6'b000100,
        PH_PIXELS        = 6'b001000,
        PH_DONE          = 6'b010000,
        PH_HALTED        = 6'b100000
    } parse_phase_t;

    // Tracks the parser state for every accepted request and keeps the results it
    // must produce, oldest first.
    class pixel_scoreboard;
        parse_phase_t phase;
        bit           in_comment;
        int unsigned  token;
        bit           have_digits;
        bit           binary;
        logic [1:0]   field;
        int unsigned  width;
        int unsigned  height;
        int unsigned  maxval;
        logic [1:0]   slot;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [23:0]  count;
        result_item_t pending[$];
        int           mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            phase       = PH_EXPECT_P;
            in_comment  = 1'b0;
            token       = 0;
            have_digits = 1'b0;
            binary      = 1'b0;
            field       = HF_WIDTH;
            width       = 0;
            height      = 0;
            maxval      = 0;
            slot        = SLOT_RED;
            red         = '0;
            green       = '0;
            count       = '0;
        endfunction

        function int unsigned clip(int unsigned v, int unsigned hi);
            return (v < hi) ? v : hi;
        endfunction

        function void push_event(logic [1:0] ev, logic [31:0] word, logic [23:0] idx,
                                 logic is_last, logic [2:0] err);
            result_item_t r;
            r.event_res    = ev;
            r.pixel_word   = word;
            r.pixel_index  = idx;
            r.last_pixel   = is_last;
            r.image_width  = width[12:0];
            r.image_height = height[12:0];
            r.max_value    = maxval[15:0];
            r.error_code   = err;
            pending.insert(pending.size(), r);
        endfunction

        function void raise_error(logic [2:0] err);
            phase = PH_HALTED;
            push_event(EV_ERROR, '0, '0, 1'b0, err);
        endfunction

        // A finished token is either a header field or one color channel.
        function void take_value(int unsigned v);
            int unsigned total;
            logic [7:0]  shade;
            logic        is_last;
            if (phase == PH_HEADER)
            begin
                case (field)
                    HF_WIDTH:
                    begin
                        width = clip(v, MAX_DIM);
                        field = HF_HEIGHT;
                    end
                    HF_HEIGHT:
                    begin
                        height = clip(v, MAX_DIM);
                        field  = HF_MAXVAL;
                    end
                    default:
                    begin
                        maxval = clip(v, MAXVAL_CAP);
                        field  = HF_DONE;
                        phase  = (width * height == 0) ? PH_DONE : PH_PIXELS;
                        push_event(EV_HEADER, '0, '0, 1'b0, ERR_NONE);
                    end
                endcase
                return;
            end
            shade = 8'(clip(clip(v, maxval), 255));
            case (slot)
                SLOT_RED:
                begin
                    red  = shade;
                    slot = SLOT_GREEN;
                end
                SLOT_GREEN:
                begin
                    green = shade;
                    slot  = SLOT_BLUE;
                end
                default:
                begin
                    slot = SLOT_RED;
                    if (phase == PH_DONE)
                    begin
                        raise_error(ERR_PIXELS);
                    end
                    else
                    begin
                        total   = width * height;
                        is_last = (count == total - 1);
                        push_event(EV_PIXEL, {ALPHA, shade, green, red}, count, is_last,
                                   ERR_NONE);
                        if (is_last)
                            phase = PH_DONE;
                        else
                            count = count + 1'b1;
                    end
                end
            endcase
        endfunction

        // Returns 0 when a halted parser simply drops the request.
        function bit note_request(char_item_t req);
            logic [7:0]  ch;
            int unsigned v;
            ch = req.data_byte;
            if (req.new_file)
                restart();
            case (phase)
                PH_EXPECT_P:
                begin
                    if (ch != CH_P)
                        raise_error(ERR_NO_P);
                    else
                        phase = PH_EXPECT_FORMAT;
                    return 1'b1;
                end
                PH_EXPECT_FORMAT:
                begin
                    if (ch == CH_3)
                        binary = 1'b0;
                    else if (ch == CH_6)
                        binary = 1'b1;
                    else
                    begin
                        raise_error(ERR_FORMAT);
                        return 1'b1;
                    end
                    phase = PH_HEADER;
                    return 1'b1;
                end
                PH_HALTED:
                    return 1'b0;
                default:
                    ;
            endcase

            // Binary files stop at the first byte after the header.
            if (phase != PH_HEADER && binary)
            begin
                raise_error(ERR_BINARY);
                return 1'b1;
            end
            if (in_comment)
            begin
                if (ch == CH_NL)
                    in_comment = 1'b0;
                return 1'b1;
            end
            if (ch == CH_HASH)
            begin
                in_comment = 1'b1;
                return 1'b1;
            end
            if (ch == CH_SPACE || ch == CH_NL)
            begin
                if (have_digits)
                begin
                    v           = token;
                    token       = 0;
                    have_digits = 1'b0;
                    take_value(v);
                end
                return 1'b1;
            end
            if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                token       = clip(token * 10 + (ch - CH_ZERO), TOKEN_CAP);
                have_digits = 1'b1;
            end
            return 1'b1;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                return;
            end
            want = pending.pop_front();
            compare("event_res", 32'(want.event_res), 32'(got.event_res));
            compare("pixel_word", want.pixel_word, got.pixel_word);
            compare("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
            compare("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
            compare("image_width", 32'(want.image_width), 32'(got.image_width));
            compare("image_height", 32'(want.image_height), 32'(got.image_height));
            compare("max_value", 32'(want.max_value), 32'(got.max_value));
            compare("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_stall;
    char_item_t   char_data;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_data;

    pixel_scoreboard sb;
    logic [7:0]      file_bytes[$];
    int              live_bytes;
    int              burst_left;
    int              idle_cycles;
    bit              hold_req;
    bit              steady_send;

    ascii_ppm_pixel_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Predict on every accepted request and check every accepted result.
    always @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            if (sb.note_request(char_data))
                live_bytes++;
        end
        if (result_valid && !result_stall)
            sb.check_result(result_data);
    end

    // The run ends if neither channel moves for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // The result side stalls in changing patterns, with one long hold on request.
    initial
    begin
        int   mode;
        int   mode_left;
        int   tick;
        int   held;
        logic stall_next;
        result_stall = 1'b0;
        mode         = 0;
        mode_left    = 0;
        tick         = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 99) < 30);
                    2: stall_next = ($urandom_range(0, 99) < 75);
                    default: stall_next = ((tick % 8) < 3);
                endcase
                result_stall <= stall_next;
            end
        end
    end

    function automatic void put_char(logic [7:0] c);
        file_bytes.insert(file_bytes.size(), c);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endfunction

    // Any character the parser ignores without ending a token.
    function automatic logic [7:0] pick_junk();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_HASH || c == CH_SPACE ||
               c == CH_NL);
        return c;
    endfunction

    function automatic void put_comment();
        logic [7:0] c;
        put_char(CH_HASH);
        repeat ($urandom_range(0, 8))
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_NL);
            put_char(c);
        end
        put_char(CH_NL);
    endfunction

    // One or more delimiters, sometimes with a comment; repeats give empty tokens.
    function automatic void put_gap();
        repeat ($urandom_range(1, 3))
        begin
            put_char($urandom_range(0, 1) ? CH_SPACE : CH_NL);
            if ($urandom_range(0, 7) == 0)
                put_comment();
        end
    endfunction

    // A decimal token, at times with leading zeros, junk or a comment inside it.
    function automatic void put_value(int unsigned v);
        string digits;
        int    quirk;
        digits = $sformatf("%0d", v);
        quirk  = $urandom_range(0, 19);
        if (quirk == 0)
            put_char(CH_ZERO);
        else if (quirk == 1)
            put_text("00");
        for (int i = 0; i < digits.len(); i++)
        begin
            put_char(digits[i]);
            if (i == 0 && quirk == 2)
                put_char(pick_junk());
            if (i == 0 && quirk == 3)
                put_comment();
        end
        put_gap();
    endfunction

    function automatic void put_pixel_value(int unsigned mv);
        case ($urandom_range(0, 9))
            0:
            begin
                repeat ($urandom_range(7, 12))
                    put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                put_gap();
            end
            1: put_value($urandom_range(0, 1000));
            2: put_value(0);
            3: put_value(255);
            default: put_value($urandom_range(0, (mv > 255) ? 255 : mv));
        endcase
    endfunction

    function automatic void make_p3(int unsigned w, int unsigned h, int unsigned mv,
                                    int unsigned values);
        put_text("P3");
        if ($urandom_range(0, 3) != 0)
            put_gap();
        put_value(w);
        put_value(h);
        put_value(mv);
        repeat (values)
            put_pixel_value(mv);
    endfunction

    // Mostly well-formed files with random content; the rest are broken or noise.
    function automatic void make_random_file();
        int          kind;
        int          pick;
        int unsigned w;
        int unsigned h;
        int unsigned mv;
        int unsigned values;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                w = 0;
                h = $urandom_range(0, 3);
            end
            else if (pick == 1)
            begin
                w = $urandom_range(4097, 999999999);
                h = 0;
            end
            else if (pick == 2)
            begin
                w = $urandom_range(1, 3);
                h = $urandom_range(4097, 200000);
            end
            else if (pick == 3)
            begin
                w = $urandom_range(5, 8);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 4);
            end
            case ($urandom_range(0, 9))
                0: mv = $urandom_range(0, 15);
                1: mv = MAXVAL_CAP;
                2: mv = $urandom_range(65536, 999999);
                3: mv = 255;
                4: mv = 1;
                default: mv = $urandom_range(16, 1000);
            endcase
            values = ((w > MAX_DIM) ? MAX_DIM : w) * ((h > MAX_DIM) ? MAX_DIM : h) * 3;
            if (pick == 2)
                values = $urandom_range(0, 12);
            else
            begin
                case ($urandom_range(0, 9))
                    0: values = values + $urandom_range(1, 6);
                    1: values = $urandom_range(0, values);
                    default: ;
                endcase
            end
            make_p3(w, h, mv, values);
        end
        else if (kind < 78)
        begin
            put_text("P6");
            repeat (3)
                put_value($urandom_range(0, 3));
            repeat ($urandom_range(1, 4))
                put_char(8'($urandom_range(0, 255)));
        end
        else if (kind < 86)
        begin
            put_char($urandom_range(0, 1) ? CH_P : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 5))
                put_char(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 1))
                put_text("P3");
            repeat ($urandom_range(5, 20))
                put_char(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one request and wait for it to be taken; bursts end in a random gap unless sending is steady.
    task automatic send_byte(logic [7:0] c, logic nf);
        char_item_t req;
        req.data_byte = c;
        req.new_file  = nf;
        char_data  <= req;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            if (!steady_send)
            begin
                char_valid <= 1'b0;
                repeat ($urandom_range(1, 10))
                    @(negedge clk);
            end
        end
    endtask

    task automatic send_file(logic first_flag);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], (i == 0) ? first_flag : 1'b0);
        file_bytes.delete();
    endtask

    // Stop sending until every predicted result has been checked.
    task automatic wait_drained();
        char_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        sb          = new();
        live_bytes  = 0;
        burst_left  = 1;
        hold_req    = 1'b0;
        steady_send = 1'b0;
        char_valid  = 1'b0;
        char_data   = '0;
        rst_n       = 1'b0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Missing magic, unknown format, binary file with a halted tail byte,
        // and an empty image that receives an extra pixel.
        put_text("Q");
        send_file(1'b1);
        put_char(CH_P);
        put_char(8'h00);
        send_file(1'b1);
        put_text("P61 1 1 A");
        put_char(8'hFF);
        send_file(1'b1);
        put_text("P30 0 0 1 2 3 ");
        send_file(1'b1);
        wait_drained();

        // Long hold on the result side while requests keep coming.
        make_p3(4, 4, 255, 48);
        @(posedge clk);
        hold_req    = 1'b1;
        steady_send = 1'b1;
        @(negedge clk);
        send_file(1'b1);
        steady_send = 1'b0;
        wait_drained();

        while (live_bytes < RANDOM_BYTES)
        begin
            make_random_file();
            send_file(($urandom_range(0, 19) != 0) ? 1'b1 : 1'b0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
